[rtl/pbl_pkg.sv]
// Package for the poly-ball line evaluator: sizes, codes, state encoding and
// the structures passed between the controller and the datapath.
// No dependencies.
package pbl_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned MAX_LINES  = 256;
  localparam int unsigned PT_AW      = 10;
  localparam int unsigned PC_W       = 11;
  localparam int unsigned LC_W       = 9;
  localparam int unsigned LINE_W     = 8;
  localparam int unsigned SEG_W      = 10;
  localparam int unsigned ACC_W      = 70;
  localparam int unsigned OP_W       = 34;
  localparam int unsigned PROD_W     = 68;
  localparam int unsigned DIV_W      = 89;
  localparam int unsigned Q_W        = 21;
  localparam int unsigned T_W        = 17;
  localparam int unsigned TQ_W       = 22;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DIV_STEPS  = 21;

  typedef enum logic [1:0] {
    OPC_CLEAR = 2'd0,
    OPC_LOAD  = 2'd1,
    OPC_QUERY = 2'd2,
    OPC_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_NOSEG  = 2'd2,
    STS_UNUSED = 2'd3
  } status_e;

  typedef enum logic {
    CFG_USE_RADIUS = 1'b0,
    CFG_TOLERANCE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MS_NUM_X = 4'd0,  MS_NUM_Y = 4'd1,  MS_NUM_Z = 4'd2,  MS_NUM_R = 4'd3,
    MS_DEN_X = 4'd4,  MS_DEN_Y = 4'd5,  MS_DEN_Z = 4'd6,  MS_DEN_R = 4'd7,
    MS_CEN_X = 4'd8,  MS_CEN_Y = 4'd9,  MS_CEN_Z = 4'd10, MS_CEN_R = 4'd11,
    MS_VAL_X = 4'd12, MS_VAL_Y = 4'd13, MS_VAL_Z = 4'd14, MS_VAL_R = 4'd15
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SHF, S_DIFF, S_MACA, S_CHK, S_DIV, S_TSEL, S_MACB, S_CMP, S_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        r;
    logic [LINE_W-1:0]  line;
  } point_t;

  typedef struct packed {
    logic              wr_en;
    logic [PT_AW-1:0]  wr_addr;
    logic [LINE_W-1:0] wr_line;
    logic              q_load;
    logic              q_empty;
    logic              rd_en;
    logic [PT_AW-1:0]  rd_addr;
    logic              shift;
    logic              first;
    logic              diff;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              div_init;
    logic              div_step;
    logic              tsel;
    logic              cmp;
  } cmd_t;

  typedef struct packed {
    logic line_eq;
    logic skip;
  } sts_t;

  typedef struct packed {
    status_e            status;
    logic signed [63:0] min_value;
    logic [LINE_W-1:0]  line_index;
    logic [SEG_W-1:0]   segment_index;
    logic [T_W-1:0]     position_t;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] center_radius;
  } res_t;

endpackage

[rtl/pbl_if.sv]
// Channel interfaces of the poly-ball line evaluator: input items and results.
// Depends on nothing.
interface pbl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [30:0]        ball_radius;
  logic               new_line;
  modport source (output valid, opcode, coord_x, coord_y, coord_z, ball_radius, new_line,
                  input ready);
  modport sink (input valid, opcode, coord_x, coord_y, coord_z, ball_radius, new_line,
                output ready);
endinterface

interface pbl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] min_value;
  logic [7:0]         line_index;
  logic [9:0]         segment_index;
  logic [16:0]        position_t;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] center_radius;
  modport source (output valid, status, min_value, line_index, segment_index, position_t,
                  center_x, center_y, center_z, center_radius, input ready);
  modport sink (input valid, status, min_value, line_index, segment_index, position_t,
                center_x, center_y, center_z, center_radius, output ready);
endinterface

[rtl/pbl_ctrl.sv]
// Controller of the poly-ball line evaluator: point and line counts, the
// segment sweep and the per-segment step sequence. Uses pbl_pkg.
module pbl_ctrl import pbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_opcode_i,
  input  logic              in_new_line_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d, idx_q, idx_d;
  logic [LC_W-1:0]   lc_q, lc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              accept, ld_new, ld_ok, seg, adv_last;
  opcode_e           opc;

  assign opc      = opcode_e'(in_opcode_i);
  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign ld_new   = in_new_line_i || (pc_q == '0);
  assign ld_ok    = (pc_q < PC_W'(MAX_POINTS)) && !(ld_new && (lc_q >= LC_W'(MAX_LINES)));
  assign seg      = (idx_q != '0) && sts_i.line_eq;
  assign adv_last = (idx_q + PC_W'(1)) >= pc_q;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    lc_d    = lc_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opc)
            OPC_CLEAR: begin
              pc_d = '0;
              lc_d = '0;
            end
            OPC_LOAD: begin
              if (ld_ok) begin
                pc_d = pc_q + PC_W'(1);
                if (ld_new) begin
                  lc_d = lc_q + LC_W'(1);
                end
              end
            end
            OPC_QUERY: begin
              idx_d   = '0;
              state_d = (pc_q == '0) ? S_OUT : S_RD;
            end
            OPC_NONE: begin
            end
          endcase
        end
      end
      S_RD: state_d = S_SHF;
      S_SHF: begin
        if (seg) begin
          state_d = S_DIFF;
        end else if (adv_last) begin
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + PC_W'(1);
          state_d = S_RD;
        end
      end
      S_DIFF: begin
        cnt_d   = '0;
        state_d = S_MACA;
      end
      S_MACA: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(8)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cnt_d = '0;
        if (!sts_i.skip) begin
          state_d = S_DIV;
        end else if (adv_last) begin
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + PC_W'(1);
          state_d = S_RD;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_TSEL;
        end
      end
      S_TSEL: begin
        cnt_d   = CNT_W'(8);
        state_d = S_MACB;
      end
      S_MACB: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(16)) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (adv_last) begin
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + PC_W'(1);
          state_d = S_RD;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = mul_sel_e'(cnt_q[3:0]);
    cmd_o.wr_addr  = pc_q[PT_AW-1:0];
    cmd_o.wr_line  = ld_new ? lc_q[LINE_W-1:0] : LINE_W'(lc_q - LC_W'(1));
    cmd_o.rd_addr  = idx_q[PT_AW-1:0];
    cmd_o.q_empty  = (pc_q == '0);
    cmd_o.first    = (idx_q == '0);
    in_ready_o     = (state_q == S_IDLE);
    out_valid_o    = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.wr_en  = accept && (opc == OPC_LOAD) && ld_ok;
        cmd_o.q_load = accept && (opc == OPC_QUERY);
      end
      S_RD:   cmd_o.rd_en    = 1'b1;
      S_SHF:  cmd_o.shift    = 1'b1;
      S_DIFF: cmd_o.diff     = 1'b1;
      S_MACA: cmd_o.mul_en   = (cnt_q <= CNT_W'(7));
      S_CHK:  cmd_o.div_init = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_TSEL: cmd_o.tsel     = 1'b1;
      S_MACB: cmd_o.mul_en   = (cnt_q <= CNT_W'(15));
      S_CMP:  cmd_o.cmp      = 1'b1;
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      lc_q    <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      lc_q    <= lc_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/pbl_dp.sv]
// Datapath of the poly-ball line evaluator: point memory, shared multiplier,
// accumulators, restoring divider and the running minimum. Uses pbl_pkg.
module pbl_dp import pbl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [30:0]        ball_radius_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output res_t               res_o
);

  point_t                    mem [MAX_POINTS];
  point_t                    rdata_q, p0_q, p1_q;
  logic signed [31:0]        qx_q, qy_q, qz_q;
  logic signed [32:0]        dx_q, dy_q, dz_q, wx_q, wy_q, wz_q;
  logic signed [31:0]        dr_q;
  logic [30:0]               r0_q;
  logic signed [ACC_W-1:0]   num_q, den_q, val_q, best_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  mul_sel_e                  psel_q;
  logic                      pv_q;
  logic [DIV_W-1:0]          rem_q, dsh_q;
  logic [Q_W-1:0]            quo_q;
  logic                      cap_q, neg_q;
  logic [T_W-1:0]            t_q;
  logic signed [32:0]        cx_q, cy_q, cz_q, cr_q;
  logic [SEG_W-1:0]          pos_q;
  logic                      found_q;
  logic                      use_q;
  logic [15:0]               tol_q;
  res_t                      res_q;

  logic signed [OP_W-1:0]    ma, mb, ex, ey, ez;
  logic signed [ACC_W-1:0]   p70, val_sum;
  logic [ACC_W-1:0]          absn, absd;
  logic [DIV_W-1:0]          nn, dd;
  logic                      ge;
  logic [Q_W-1:0]            mag;
  logic signed [TQ_W-1:0]    tq, tol_s, one_m;
  logic [30:0]               r0e, r1e;
  logic [63:0]               sat;
  logic signed [34:0]        pshift;

  assign ex = OP_W'(qx_q) - OP_W'(cx_q);
  assign ey = OP_W'(qy_q) - OP_W'(cy_q);
  assign ez = OP_W'(qz_q) - OP_W'(cz_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_NUM_X: begin ma = OP_W'(dx_q); mb = OP_W'(wx_q); end
      MS_NUM_Y: begin ma = OP_W'(dy_q); mb = OP_W'(wy_q); end
      MS_NUM_Z: begin ma = OP_W'(dz_q); mb = OP_W'(wz_q); end
      MS_NUM_R: begin ma = OP_W'(dr_q); mb = signed'(OP_W'(r0_q)); end
      MS_DEN_X: begin ma = OP_W'(dx_q); mb = OP_W'(dx_q); end
      MS_DEN_Y: begin ma = OP_W'(dy_q); mb = OP_W'(dy_q); end
      MS_DEN_Z: begin ma = OP_W'(dz_q); mb = OP_W'(dz_q); end
      MS_DEN_R: begin ma = OP_W'(dr_q); mb = OP_W'(dr_q); end
      MS_CEN_X: begin ma = signed'(OP_W'(t_q)); mb = OP_W'(dx_q); end
      MS_CEN_Y: begin ma = signed'(OP_W'(t_q)); mb = OP_W'(dy_q); end
      MS_CEN_Z: begin ma = signed'(OP_W'(t_q)); mb = OP_W'(dz_q); end
      MS_CEN_R: begin ma = signed'(OP_W'(t_q)); mb = OP_W'(dr_q); end
      MS_VAL_X: begin ma = ex; mb = ex; end
      MS_VAL_Y: begin ma = ey; mb = ey; end
      MS_VAL_Z: begin ma = ez; mb = ez; end
      MS_VAL_R: begin ma = OP_W'(cr_q); mb = OP_W'(cr_q); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_d  = ma * mb;
  assign p70     = ACC_W'(prod_q);
  assign pshift  = 35'(prod_q >>> 16);
  assign val_sum = val_q;

  assign absn  = num_q[ACC_W-1] ? ACC_W'(-num_q) : ACC_W'(num_q);
  assign absd  = den_q[ACC_W-1] ? ACC_W'(-den_q) : ACC_W'(den_q);
  assign nn    = DIV_W'(absn) << 16;
  assign dd    = DIV_W'(absd);
  assign ge    = rem_q >= dsh_q;
  assign mag   = (cap_q || (quo_q > Q_W'(1 << 20))) ? Q_W'(1 << 20) : quo_q;
  assign tq    = neg_q ? -signed'(TQ_W'(mag)) : signed'(TQ_W'(mag));
  assign tol_s = signed'(TQ_W'(tol_q));
  assign one_m = signed'(TQ_W'(1 << 16)) - tq;
  assign r0e   = use_q ? p0_q.r : '0;
  assign r1e   = use_q ? p1_q.r : '0;

  assign sts_o.line_eq = (rdata_q.line == p1_q.line);
  assign sts_o.skip    = (den_q == '0) || (absd < ACC_W'({tol_q, 16'h0000}));

  always_comb begin
    if ((&val_q[ACC_W-1:63]) || !(|val_q[ACC_W-1:63])) begin
      sat = val_q[63:0];
    end else if (val_q[ACC_W-1]) begin
      sat = 64'h8000_0000_0000_0000;
    end else begin
      sat = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q   <= 1'b1;
      tol_q   <= 16'd1;
      pv_q    <= 1'b0;
    end else begin
      pv_q <= cmd_i.mul_en;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_USE_RADIUS: use_q <= cfg_data_i[0];
          CFG_TOLERANCE:  tol_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= '{x: coord_x_i, y: coord_y_i, z: coord_z_i,
                              r: ball_radius_i, line: cmd_i.wr_line};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      qx_q    <= coord_x_i;
      qy_q    <= coord_y_i;
      qz_q    <= coord_z_i;
      found_q <= 1'b0;
      res_q   <= '{status: (cmd_i.q_empty ? STS_EMPTY : STS_NOSEG), default: '0};
    end
    if (cmd_i.shift) begin
      p0_q  <= p1_q;
      p1_q  <= rdata_q;
      pos_q <= (cmd_i.first || !sts_o.line_eq) ? '0 : pos_q + SEG_W'(1);
    end
    if (cmd_i.diff) begin
      dx_q  <= 33'(p1_q.x) - 33'(p0_q.x);
      dy_q  <= 33'(p1_q.y) - 33'(p0_q.y);
      dz_q  <= 33'(p1_q.z) - 33'(p0_q.z);
      wx_q  <= 33'(qx_q) - 33'(p0_q.x);
      wy_q  <= 33'(qy_q) - 33'(p0_q.y);
      wz_q  <= 33'(qz_q) - 33'(p0_q.z);
      dr_q  <= signed'({1'b0, r1e}) - signed'({1'b0, r0e});
      r0_q  <= r0e;
      num_q <= '0;
      den_q <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      psel_q <= cmd_i.mul_sel;
    end
    if (pv_q) begin
      unique case (psel_q)
        MS_NUM_X, MS_NUM_Y, MS_NUM_Z, MS_NUM_R: num_q <= num_q + p70;
        MS_DEN_X, MS_DEN_Y, MS_DEN_Z:           den_q <= den_q + p70;
        MS_DEN_R:                               den_q <= den_q - p70;
        MS_CEN_X: cx_q <= 33'(35'(p0_q.x) + pshift);
        MS_CEN_Y: cy_q <= 33'(35'(p0_q.y) + pshift);
        MS_CEN_Z: cz_q <= 33'(35'(p0_q.z) + pshift);
        MS_CEN_R: cr_q <= 33'(signed'(35'(r0_q)) + pshift);
        MS_VAL_X, MS_VAL_Y, MS_VAL_Z:           val_q <= val_sum + p70;
        MS_VAL_R:                               val_q <= val_sum - p70;
        default: begin
        end
      endcase
    end
    if (cmd_i.div_init) begin
      rem_q <= nn;
      dsh_q <= dd << 20;
      quo_q <= '0;
      cap_q <= nn >= (dd << 21);
      neg_q <= num_q[ACC_W-1] ^ den_q[ACC_W-1];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_q - dsh_q : rem_q;
      quo_q <= {quo_q[Q_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.tsel) begin
      val_q <= '0;
      if (tq < tol_s) begin
        t_q <= '0;
      end else if (one_m < tol_s) begin
        t_q <= T_W'(1 << 16);
      end else begin
        t_q <= tq[T_W-1:0];
      end
    end
    if (cmd_i.cmp) begin
      if (!found_q || (val_q < best_q)) begin
        found_q                <= 1'b1;
        best_q                 <= val_q;
        res_q.status           <= STS_OK;
        res_q.min_value        <= signed'(sat);
        res_q.line_index       <= p0_q.line;
        res_q.segment_index    <= pos_q - SEG_W'(1);
        res_q.position_t       <= t_q;
        res_q.center_x         <= cx_q[31:0];
        res_q.center_y         <= cy_q[31:0];
        res_q.center_z         <= cz_q[31:0];
        res_q.center_radius    <= cr_q[31:0];
      end
    end
  end

  assign res_o = res_q;

endmodule

[rtl/polyball_line_min_eval_core.sv]
// Top level of the poly-ball line evaluator: controller, datapath and the
// channel interfaces. Uses pbl_pkg, pbl_if, pbl_ctrl and pbl_dp.
//
// Items arrive on in_item; a transfer takes place when valid and ready are
// both high. Clear and load items give no result. A query sweeps every
// stored point once and gives one result on out_item, which holds it until
// the receiver takes the transfer; no new item is taken until then. A query
// on an empty store goes straight to the result, with status empty.
// Otherwise each point costs a memory read and line check, and each segment
// eight products on the one shared multiplier; a non-degenerate segment
// then takes a 21-step restoring divide for t, eight more products and the
// compare. Configuration writes on cfg_we_i apply at once; they are to be
// made while the block is idle, which the block itself does not enforce.
// Reset empties the store and sets use_radius and tolerance to one; the
// point memory is not cleared, as only loaded entries are ever read.
module polyball_line_min_eval_core import pbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbl_in_if.sink      in_item,
  pbl_out_if.source   out_item,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  pbl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_item.valid),
    .in_opcode_i   (in_item.opcode),
    .in_new_line_i (in_item.new_line),
    .in_ready_o    (in_item.ready),
    .out_valid_o   (out_item.valid),
    .out_ready_i   (out_item.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  pbl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .coord_x_i     (in_item.coord_x),
    .coord_y_i     (in_item.coord_y),
    .coord_z_i     (in_item.coord_z),
    .ball_radius_i (in_item.ball_radius),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_o         (res)
  );

  assign out_item.status        = res.status;
  assign out_item.min_value     = res.min_value;
  assign out_item.line_index    = res.line_index;
  assign out_item.segment_index = res.segment_index;
  assign out_item.position_t    = res.position_t;
  assign out_item.center_x      = res.center_x;
  assign out_item.center_y      = res.center_y;
  assign out_item.center_z      = res.center_z;
  assign out_item.center_radius = res.center_radius;

endmodule
